### design/u8cvt_pkg.sv
// ----------------------------------------------------------------------------
// u8cvt_pkg
// Shared types and constants for the UTF-8 to UTF-16/UTF-32 converter.
// ----------------------------------------------------------------------------
package u8cvt_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] ASCII_LIM = 8'h80;
  localparam logic [7:0] LEAD_MIN  = 8'hC2;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD_LIM  = 8'hF5;

  localparam logic [7:0] MASK2 = 8'h1F;
  localparam logic [7:0] MASK3 = 8'h0F;
  localparam logic [7:0] MASK4 = 8'h07;

  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;

  localparam logic [2:0] CFG_ADDR_MODE = 3'b000;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_BADLEAD = 2'd2
  } status_t;

  typedef struct packed {
    logic [20:0] code;
    logic        fin;
    status_t     status;
  } evt_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

### design/u8cvt_if.sv
// ----------------------------------------------------------------------------
// u8cvt interfaces
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface u8cvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface u8cvt_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_unit;
  logic        run_last;
  logic        stream_end;
  logic [1:0]  status;

  modport source (output valid, output code_unit, output run_last,
                  output stream_end, output status, input ready);
  modport sink   (input valid, input code_unit, input run_last,
                  input stream_end, input status, output ready);
endinterface

### design/u8cvt_front.sv
// ----------------------------------------------------------------------------
// u8cvt_front
// Accept bytes, track the open sequence and push one event per character,
// invalid lead or truncated buffer.
// ----------------------------------------------------------------------------
module u8cvt_front (
  input  logic              clk,
  input  logic              rst_n,
  u8cvt_in_if.sink          in_ch,
  input  u8cvt_pkg::q_stat_t qstat,
  output logic              push,
  output u8cvt_pkg::evt_t   push_evt
);
  import u8cvt_pkg::*;

  logic [1:0]  rem_r, rem_nxt;
  logic [20:0] part_r, part_nxt;
  logic        acc;
  logic [7:0]  b;
  logic        lst;
  logic [20:0] cont_val;
  logic [1:0]  cont_rem;

  assign in_ch.ready = !qstat.full;
  assign acc      = in_ch.valid && in_ch.ready;
  assign b        = in_ch.byte_in;
  assign lst      = in_ch.last_byte;
  assign cont_val = {part_r[14:0], b[5:0]};
  assign cont_rem = rem_r - 2'd1;

  always_comb begin
    rem_nxt  = rem_r;
    part_nxt = part_r;
    push     = 1'b0;
    push_evt = '{code: '0, fin: lst, status: ST_OK};
    if (acc) begin
      if (rem_r == 2'd0) begin
        if (b < ASCII_LIM) begin
          push          = 1'b1;
          push_evt.code = {13'd0, b};
        end else if (b < LEAD_MIN || b >= LEAD_LIM) begin
          push            = 1'b1;
          push_evt.status = ST_BADLEAD;
        end else if (lst) begin
          push            = 1'b1;
          push_evt.status = ST_TRUNC;
        end else if (b < LEAD3_MIN) begin
          rem_nxt  = 2'd1;
          part_nxt = {13'd0, b & MASK2};
        end else if (b < LEAD4_MIN) begin
          rem_nxt  = 2'd2;
          part_nxt = {13'd0, b & MASK3};
        end else begin
          rem_nxt  = 2'd3;
          part_nxt = {13'd0, b & MASK4};
        end
      end else begin
        if (cont_rem == 2'd0) begin
          push          = 1'b1;
          push_evt.code = cont_val;
          rem_nxt       = 2'd0;
          part_nxt      = '0;
        end else if (lst) begin
          push            = 1'b1;
          push_evt.status = ST_TRUNC;
          rem_nxt         = 2'd0;
          part_nxt        = '0;
        end else begin
          rem_nxt  = cont_rem;
          part_nxt = cont_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= 2'd0;
      part_r <= '0;
    end else begin
      rem_r  <= rem_nxt;
      part_r <= part_nxt;
    end
  end

  a_trunc_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_evt.status == ST_TRUNC |=> rem_r == 2'd0 && part_r == '0)
    else $error("state not cleared after truncation");

  a_badlead_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_evt.status == ST_BADLEAD |=> $stable(rem_r) && rem_r == 2'd0)
    else $error("invalid lead changed state");

  a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("push into full queue");

endmodule

### design/u8cvt_queue.sv
// ----------------------------------------------------------------------------
// u8cvt_queue
// Short event queue between the byte front and the result back.
// ----------------------------------------------------------------------------
module u8cvt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  u8cvt_pkg::evt_t    push_evt,
  input  logic               pop,
  output u8cvt_pkg::evt_t    head_evt,
  output u8cvt_pkg::q_stat_t qstat
);
  import u8cvt_pkg::*;

  evt_t           mem [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign qstat.empty = (cnt_r == '0);
  assign qstat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign head_evt    = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("queue count overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.empty |-> wp_r == rp_r)
    else $error("pointers out of step");

endmodule

### design/u8cvt_back.sv
// ----------------------------------------------------------------------------
// u8cvt_back
// Drain events into the output register, splitting supplementary scalars
// into surrogate pairs in UTF-16 mode.
// ----------------------------------------------------------------------------
module u8cvt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mode,
  input  u8cvt_pkg::evt_t    head_evt,
  input  u8cvt_pkg::q_stat_t qstat,
  output logic               pop,
  u8cvt_out_if.source        out_ch
);
  import u8cvt_pkg::*;

  logic        vld_r;
  logic        half_r;
  logic [20:0] code_r, code_nxt;
  logic        rlast_r, rlast_nxt;
  logic        end_r, end_nxt;
  status_t     st_r;
  logic        ld;
  logic        pair;
  logic [19:0] off;

  assign ld   = !vld_r || out_ch.ready;
  assign off  = head_evt.code[19:0] - SUPP_BASE[19:0];
  assign pair = (head_evt.status == ST_OK) && !mode && (|head_evt.code[20:16]);
  assign pop  = ld && !qstat.empty && (!pair || half_r);

  always_comb begin
    code_nxt  = head_evt.code;
    rlast_nxt = 1'b1;
    end_nxt   = head_evt.fin;
    if (pair) begin
      if (half_r) begin
        code_nxt = {5'd0, LO_SURR_TAG, off[9:0]};
      end else begin
        code_nxt  = {5'd0, HI_SURR_TAG, off[19:10]};
        rlast_nxt = 1'b0;
        end_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld && !qstat.empty) begin
      code_r  <= code_nxt;
      rlast_r <= rlast_nxt;
      end_r   <= end_nxt;
      st_r    <= head_evt.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      half_r <= 1'b0;
    end else if (ld) begin
      vld_r  <= !qstat.empty;
      half_r <= !qstat.empty && pair && !half_r;
    end
  end

  assign out_ch.valid      = vld_r;
  assign out_ch.code_unit  = code_r;
  assign out_ch.run_last   = rlast_r;
  assign out_ch.stream_end = end_r;
  assign out_ch.status     = st_r;

  a_half_held: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> vld_r && !qstat.empty)
    else $error("pair split without pending entry");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && st_r != ST_OK |-> code_r == '0 && rlast_r)
    else $error("error beat carries data");

  a_hi_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> !rlast_r && !end_r)
    else $error("high surrogate marked last");

endmodule

### design/utf8_to_utf16_utf32_converter.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_utf32_converter
// UTF-8 byte stream decoder emitting UTF-16 code units or UTF-32 scalars.
//
//   channel  dir  handshake          beat
//   in_ch    in   valid/ready        byte_in, last_byte
//   out_ch   out  valid/ready        code_unit, run_last, stream_end, status
//   cfg_*    in   APB, pready = 1    output_mode at byte addresses 0-3
//
// One byte per cycle is accepted while the 4-entry event queue has room.
// Results leave through a registered output, one beat per cycle while out_ch is ready; a
// supplementary scalar in UTF-16 mode leaves as a surrogate pair, high half first.
// Reset (rst_n low, synchronous) clears the open sequence, queue and mode.
// Input and output stall independently; the queue absorbs up to 4 events.
// ----------------------------------------------------------------------------
module utf8_to_utf16_utf32_converter (
  input  logic        clk,
  input  logic        rst_n,
  u8cvt_in_if.sink    in_ch,
  u8cvt_out_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import u8cvt_pkg::*;

  logic    mode_r;
  logic    push;
  evt_t    push_evt;
  evt_t    head_evt;
  logic    pop;
  q_stat_t qstat;
  logic    mode_sel;

  assign cfg_pready = 1'b1;
  assign mode_sel   = (cfg_paddr[2] == CFG_ADDR_MODE[2]);
  assign cfg_prdata = mode_sel ? {31'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && mode_sel) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  u8cvt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .qstat    (qstat),
    .push     (push),
    .push_evt (push_evt)
  );

  u8cvt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .head_evt (head_evt),
    .qstat    (qstat)
  );

  u8cvt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .head_evt (head_evt),
    .qstat    (qstat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
